FILE: rtl/sbpf_pkg.sv
// Shared types and constants for the servo bus instruction packet framer.
package sbpf_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 4;
  localparam int CNT_W  = 4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam byte_t HDR_BYTE = 8'hFF;
  localparam byte_t LEN_BIAS = 8'd3;

  // Byte positions within a frame
  localparam pos_t POS_HDR0  = 4'd0;
  localparam pos_t POS_HDR1  = 4'd1;
  localparam pos_t POS_ID    = 4'd2;
  localparam pos_t POS_LEN   = 4'd3;
  localparam pos_t POS_INSTR = 4'd4;
  localparam pos_t POS_ADDR  = 4'd5;
  localparam pos_t POS_PARAM = 4'd6;

endpackage

FILE: rtl/sbpf_if.sv
// Valid/ready channel interfaces for requests and packet bytes.
interface sbpf_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  servo_id;
  logic [7:0]  instruction;
  logic [7:0]  start_address;
  logic [3:0]  param_count;
  logic [63:0] param_bytes;

  modport source (output valid, servo_id, instruction, start_address, param_count,
                  param_bytes, input ready);
  modport sink   (input valid, servo_id, instruction, start_address, param_count,
                  param_bytes, output ready);
endinterface

interface sbpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       is_last;

  modport source (output valid, packet_byte, is_last, input ready);
  modport sink   (input valid, packet_byte, is_last, output ready);
endinterface

FILE: rtl/servo_bus_instruction_packet_framer.sv
// Servo bus instruction packet framer: one request in, one framed packet out.
//
// req carries one request per beat: servo id, instruction, start address,
// parameter count and up to MAX_PARAMS parameter bytes (byte 0 in the low
// bits). A count above MAX_PARAMS is clamped to MAX_PARAMS.
// pkt carries one packet byte per beat: 0xFF, 0xFF, id, length (3 + count),
// instruction, address, parameters, checksum; is_last marks the checksum.
//
// A small sequencer walks the byte positions of the frame and feeds every
// byte from the id onward through one shared 8-bit checksum adder, one byte
// per cycle while pkt.ready lets it advance. A frame with count n has
// 7 + n bytes, 15 with the maximum of eight parameters. A request beat
// loads the sequencer, and its first step loads the first header byte.
//
// req.ready is high only between packets; it rises again as soon as the
// checksum byte is loaded into the output register, even while that byte
// waits. When pkt.ready is low the output register holds its byte and the
// sequencer stalls. Synchronous reset empties the output register and
// returns the sequencer to idle; the request registers are not reset.
module servo_bus_instruction_packet_framer #(
  parameter int MAX_PARAMS = 8
) (
  input  logic          clk,
  input  logic          rst,
  sbpf_req_if.sink      req,
  sbpf_byte_if.source   pkt
);

  localparam int PW = sbpf_pkg::BYTE_W * MAX_PARAMS;
  localparam sbpf_pkg::cnt_t MAX_CNT = sbpf_pkg::cnt_t'(MAX_PARAMS);

  logic                busy;
  sbpf_pkg::pos_t      pos;
  sbpf_pkg::cnt_t      cnt;
  sbpf_pkg::byte_t     id;
  sbpf_pkg::byte_t     instr;
  sbpf_pkg::byte_t     addr;
  logic [PW-1:0]       params;
  sbpf_pkg::byte_t     sum;

  logic                out_valid;
  sbpf_pkg::byte_t     out_byte;
  logic                out_last;

  logic                req_beat;
  logic                emit;
  sbpf_pkg::pos_t      last_pos;
  logic                at_last;
  sbpf_pkg::byte_t     cur_byte;
  sbpf_pkg::byte_t     sum_next;
  sbpf_pkg::cnt_t      cnt_sat;

  assign req.ready       = !busy;
  assign req_beat        = req.valid && !busy;
  assign pkt.valid       = out_valid;
  assign pkt.packet_byte = out_byte;
  assign pkt.is_last     = out_last;

  // Advance only when the output register is free or being drained this cycle
  assign emit     = busy && (!out_valid || pkt.ready);
  assign last_pos = sbpf_pkg::POS_PARAM + sbpf_pkg::pos_t'(cnt);
  assign at_last  = (pos == last_pos);
  assign cnt_sat  = (req.param_count > MAX_CNT) ? MAX_CNT : req.param_count;

  always_comb begin
    case (pos)
      sbpf_pkg::POS_HDR0:  cur_byte = sbpf_pkg::HDR_BYTE;
      sbpf_pkg::POS_HDR1:  cur_byte = sbpf_pkg::HDR_BYTE;
      sbpf_pkg::POS_ID:    cur_byte = id;
      sbpf_pkg::POS_LEN:   cur_byte = sbpf_pkg::LEN_BIAS + sbpf_pkg::byte_t'(cnt);
      sbpf_pkg::POS_INSTR: cur_byte = instr;
      sbpf_pkg::POS_ADDR:  cur_byte = addr;
      default:             cur_byte = at_last ? ~sum : params[sbpf_pkg::BYTE_W-1:0];
    endcase
  end

  // Shared checksum adder: header bytes are kept out of the sum
  assign sum_next = (pos < sbpf_pkg::POS_ID) ? sum : sum + cur_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= sbpf_pkg::POS_HDR0;
    end else if (req_beat) begin
      busy <= 1'b1;
      pos  <= sbpf_pkg::POS_HDR0;
    end else if (emit) begin
      if (at_last) begin
        busy <= 1'b0;
      end
      pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_beat) begin
      id     <= req.servo_id;
      instr  <= req.instruction;
      addr   <= req.start_address;
      cnt    <= cnt_sat;
      params <= req.param_bytes[PW-1:0];
      sum    <= '0;
    end else if (emit) begin
      sum <= sum_next;
      // Drop each parameter byte once it has gone out
      if (pos >= sbpf_pkg::POS_PARAM) begin
        params <= params >> sbpf_pkg::BYTE_W;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pkt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= cur_byte;
      out_last <= at_last;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    req_beat |=> busy && (pos == sbpf_pkg::POS_HDR0))
    else $error("request beat did not start a frame");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pos <= last_pos))
    else $error("sequencer ran past the checksum position");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && at_last) |=> !busy && out_valid && out_last)
    else $error("checksum byte did not close the frame");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !out_valid) |=> !out_valid || $past(emit))
    else $error("output became valid without a sequencer step");

endmodule

FILE: verif/sbpf_frame_checker.sv
// Frame checker: predicts the packet bytes of every accepted request and compares each beat.
module sbpf_frame_checker #(
  parameter int MAX_PARAMS = 8
) (
  input  logic  clk,
  input  logic  rst,
  sbpf_req_if   req,
  sbpf_byte_if  pkt,
  output int    errors,
  output int    pending
);

  typedef struct packed {
    sbpf_pkg::byte_t data;
    logic            last;
  } wire_byte_t;

  wire_byte_t frame_q[$];

  // Append the whole wire image of one request to the expected byte stream
  function automatic void frame_request(sbpf_pkg::byte_t id, sbpf_pkg::byte_t instr,
                                        sbpf_pkg::byte_t addr, sbpf_pkg::cnt_t count,
                                        logic [63:0] params);
    int              n;
    int              k;
    sbpf_pkg::byte_t len;
    sbpf_pkg::byte_t sum;
    sbpf_pkg::byte_t b;
    n   = (int'(count) > MAX_PARAMS) ? MAX_PARAMS : int'(count);
    len = sbpf_pkg::LEN_BIAS + sbpf_pkg::byte_t'(n);
    frame_q.push_back({sbpf_pkg::HDR_BYTE, 1'b0});
    frame_q.push_back({sbpf_pkg::HDR_BYTE, 1'b0});
    frame_q.push_back({id, 1'b0});
    frame_q.push_back({len, 1'b0});
    frame_q.push_back({instr, 1'b0});
    frame_q.push_back({addr, 1'b0});
    sum = id + len + instr + addr;
    for (k = 0; k < n; k++) begin
      b   = params[8*k +: 8];
      sum = sum + b;
      frame_q.push_back({b, 1'b0});
    end
    frame_q.push_back({~sum, 1'b1});
  endfunction

  always @(posedge clk) begin : compare
    wire_byte_t want;
    int         bad;
    if (!rst) begin
      // Check the outgoing beat before framing a new request: bytes leave in order
      if (pkt.valid && pkt.ready) begin
        if (frame_q.size() == 0) begin
          $error("packet_byte: expected none, actual %h", pkt.packet_byte);
          errors <= errors + 1;
        end else begin
          want = frame_q.pop_front();
          bad  = 0;
          if (pkt.packet_byte !== want.data) begin
            $error("packet_byte: expected %h, actual %h", want.data, pkt.packet_byte);
            bad++;
          end
          if (pkt.is_last !== want.last) begin
            $error("is_last: expected %b, actual %b", want.last, pkt.is_last);
            bad++;
          end
          errors <= errors + bad;
        end
      end
      if (req.valid && req.ready) begin
        frame_request(req.servo_id, req.instruction, req.start_address, req.param_count,
                      req.param_bytes);
      end
      pending <= frame_q.size();
    end
  end

endmodule

FILE: verif/tb.sv
// Testbench top: drives requests and packet back-pressure, and reports the verdict.
module tb;

  localparam int MAX_PARAMS   = 8;
  localparam int RANDOM_ITEMS = 500;
  localparam int PAUSE_AT     = 300;
  localparam int PRESSURE_AT  = 120;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam sbpf_pkg::byte_t INSTR_PING       = 8'h01;
  localparam sbpf_pkg::byte_t INSTR_READ       = 8'h02;
  localparam sbpf_pkg::byte_t INSTR_WRITE      = 8'h03;
  localparam sbpf_pkg::byte_t INSTR_SYNC_WRITE = 8'h83;
  localparam sbpf_pkg::byte_t ID_BROADCAST     = 8'hFE;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   cycle_count;

  sbpf_req_if  req_ch ();
  sbpf_byte_if pkt_ch ();

  servo_bus_instruction_packet_framer #(
    .MAX_PARAMS (MAX_PARAMS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .pkt (pkt_ch)
  );

  sbpf_frame_checker #(
    .MAX_PARAMS (MAX_PARAMS)
  ) i_frame_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .pkt     (pkt_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every third stretch of forty beats runs with no idling at all
  function automatic int draw_gap(int n);
    return ((n / 40) % 3 == 1) ? 0 : $urandom_range(0, 18);
  endfunction

  // Offer one request from a falling edge and return at the falling edge after its beat
  task automatic send_request(sbpf_pkg::byte_t id, sbpf_pkg::byte_t instr,
                              sbpf_pkg::byte_t addr, sbpf_pkg::cnt_t count,
                              logic [63:0] params, int gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.servo_id      <= id;
    req_ch.instruction   <= instr;
    req_ch.start_address <= addr;
    req_ch.param_count   <= count;
    req_ch.param_bytes   <= params;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : drain
    int got;
    int hold;
    got = 0;
    pkt_ch.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      // Hold off once for a long stretch so the framer backs up onto its input
      hold = (got == PRESSURE_AT) ? LONG_HOLD : draw_gap(got);
      if (hold > 0) begin
        pkt_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      pkt_ch.ready <= 1'b1;
      @(posedge clk);
      while (!pkt_ch.valid) @(posedge clk);
      got++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int             n;
    int             k;
    sbpf_pkg::cnt_t count;
    req_ch.valid         <= 1'b0;
    req_ch.servo_id      <= '0;
    req_ch.instruction   <= '0;
    req_ch.start_address <= '0;
    req_ch.param_count   <= '0;
    req_ch.param_bytes   <= '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extremes, common instructions, saturation and ignored parameter bytes
    send_request(8'h00, INSTR_PING, 8'h00, 4'd0, 64'h0, 0);
    send_request(8'hFF, INSTR_READ, 8'h38, 4'd2, 64'h02, 0);
    send_request(8'h01, INSTR_WRITE, 8'hFF, 4'd8, {64{1'b1}}, 0);
    send_request(ID_BROADCAST, INSTR_WRITE, 8'h2A, 4'd8, 64'h0, draw_gap(0));
    for (k = 1; k < 8; k++) begin
      send_request(sbpf_pkg::byte_t'($urandom), INSTR_WRITE, sbpf_pkg::byte_t'($urandom),
                   sbpf_pkg::cnt_t'(k), {$urandom, $urandom}, $urandom_range(0, 3));
    end
    send_request(8'h05, INSTR_WRITE, 8'h10, 4'd9, {$urandom, $urandom}, 0);
    send_request(8'hFF, 8'hFF, 8'hFF, 4'd15, {64{1'b1}}, 0);
    send_request(8'h07, INSTR_PING, 8'h00, 4'd0, {64{1'b1}}, 5);
    send_request(8'h08, INSTR_WRITE, 8'h1E, 4'd3, 64'hFFFF_FFFF_FF00_0000, 0);
    send_request(8'h09, 8'h00, 8'h00, 4'd1, 64'h0, 0);
    send_request(8'hFF, 8'hFF, 8'hFF, 4'd1, 64'hFF, 0);
    send_request(ID_BROADCAST, INSTR_SYNC_WRITE, 8'h2A, 4'd8, {$urandom, $urandom}, 0);
    send_request(8'h80, 8'h7F, 8'h80, 4'd12, {$urandom, $urandom}, 2);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PAUSE_AT) begin
        // Drop valid and let every outstanding byte leave before carrying on
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      count = ($urandom_range(0, 3) == 0) ? sbpf_pkg::cnt_t'($urandom_range(0, 15))
                                          : sbpf_pkg::cnt_t'($urandom_range(0, MAX_PARAMS));
      send_request(sbpf_pkg::byte_t'($urandom), sbpf_pkg::byte_t'($urandom),
                   sbpf_pkg::byte_t'($urandom), count, {$urandom, $urandom}, draw_gap(n));
    end

    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sbpf_pkg.sv
rtl/sbpf_if.sv
rtl/servo_bus_instruction_packet_framer.sv
verif/sbpf_frame_checker.sv
verif/tb.sv
